// ===== rtl/dtt_pkg.sv =====
package dtt_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W      = $clog2(TIMER_SLOTS);
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam logic [31:0] SIGN32 = 32'h8000_0000;
    localparam logic [31:0] NO_WAIT = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        KIND_ADD     = 3'd0,
        KIND_CANCEL  = 3'd1,
        KIND_REFRESH = 3'd2,
        KIND_RESET   = 3'd3,
        KIND_TICK    = 3'd4,
        KIND_QUERY   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        OSEL_OP    = 2'd0,
        OSEL_QUERY = 2'd1,
        OSEL_PEND  = 2'd2,
        OSEL_QUIET = 2'd3
    } t_osel;

    typedef struct packed {
        logic              latch;
        logic              now_inc;
        logic              fn_clear;
        logic              fn_set;
        logic              scan_en;
        logic [SLOT_W-1:0] scan_idx;
        logic              slot_op;
        logic              expire;
        logic              out_load;
        t_osel             out_sel;
        logic              out_ok;
        logic              out_fc;
        logic              out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       in_range;
        logic       id_active;
        logic       reset_noop;
        logic       best_vld;
        logic       best_due;
        logic       best_is_id;
        logic       pend_vld;
        logic       fn;
    } t_dp_stat;

endpackage

// ===== rtl/dtt_if.sv =====
interface dtt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  timer_id;
    logic [23:0] period_ms;
    logic        repeat_mode;
    logic        start_now;
    modport source (output valid, kind, timer_id, period_ms, repeat_mode, start_now,
                    input ready);
    modport sink (input valid, kind, timer_id, period_ms, repeat_mode, start_now,
                  output ready);
endinterface

interface dtt_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  slot_out;
    logic        expired;
    logic        ok;
    logic        front_changed;
    logic [31:0] next_wait_ms;
    logic        last;
    modport source (output valid, slot_out, expired, ok, front_changed, next_wait_ms,
                    last, input ready);
    modport sink (input valid, slot_out, expired, ok, front_changed, next_wait_ms,
                  last, output ready);
endinterface

// ===== rtl/dtt_dp.sv =====
module dtt_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dtt_pkg::t_dp_cmd    i_cmd,
    output dtt_pkg::t_dp_stat   o_stat,
    input  logic [2:0]          i_kind,
    input  logic [3:0]          i_timer_id,
    input  logic [23:0]         i_period_ms,
    input  logic                i_repeat_mode,
    input  logic                i_start_now,
    output logic [3:0]          o_slot_out,
    output logic                o_expired,
    output logic                o_ok,
    output logic                o_front_changed,
    output logic [31:0]         o_next_wait_ms,
    output logic                o_last
);

    logic [2:0]  r_kind;
    logic [3:0]  r_id;
    logic [23:0] r_period;
    logic        r_rep;
    logic        r_fnow;

    logic        r_act [dtt_pkg::TIMER_SLOTS];
    logic        r_srep [dtt_pkg::TIMER_SLOTS];
    logic [23:0] r_per [dtt_pkg::TIMER_SLOTS];
    logic [31:0] r_dl  [dtt_pkg::TIMER_SLOTS];
    logic [31:0] r_now;
    logic        r_fn;

    logic                      r_best_vld;
    logic [dtt_pkg::SLOT_W-1:0] r_best;
    logic [31:0]               r_best_key;
    logic                      r_pend_vld;
    logic [dtt_pkg::SLOT_W-1:0] r_pend;

    logic [dtt_pkg::SLOT_W-1:0] id_idx;
    logic [31:0] scan_key;
    logic        scan_win;
    logic [31:0] best_dist;
    logic [31:0] start;
    logic [23:0] re_per;

    assign id_idx    = dtt_pkg::SLOT_W'(r_id);
    assign scan_key  = (r_dl[i_cmd.scan_idx] - r_now) ^ dtt_pkg::SIGN32;
    assign scan_win  = r_act[i_cmd.scan_idx] &&
                       (i_cmd.scan_idx == '0 || !r_best_vld || scan_key < r_best_key);
    assign best_dist = r_best_key ^ dtt_pkg::SIGN32;
    assign start     = r_fnow ? r_now : (r_dl[id_idx] - {8'd0, r_per[id_idx]});
    assign re_per    = (r_per[r_best] == '0) ? 24'd1 : r_per[r_best];

    always_comb begin
        o_stat.kind       = r_kind;
        o_stat.in_range   = 32'(r_id) < 32'(dtt_pkg::TIMER_SLOTS);
        o_stat.id_active  = r_act[id_idx];
        o_stat.reset_noop = (r_period == r_per[id_idx]) && !r_fnow;
        o_stat.best_vld   = r_best_vld;
        o_stat.best_due   = (best_dist == '0) || best_dist[31];
        o_stat.best_is_id = r_best_vld && (r_best == id_idx);
        o_stat.pend_vld   = r_pend_vld;
        o_stat.fn         = r_fn;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind   <= i_kind;
            r_id     <= i_timer_id;
            r_period <= i_period_ms;
            r_rep    <= i_repeat_mode;
            r_fnow   <= i_start_now;
        end
        if (i_cmd.scan_en) begin
            if (i_cmd.scan_idx == '0) begin
                r_best_vld <= r_act[i_cmd.scan_idx];
                r_best     <= i_cmd.scan_idx;
                r_best_key <= scan_key;
            end else if (scan_win) begin
                r_best_vld <= 1'b1;
                r_best     <= i_cmd.scan_idx;
                r_best_key <= scan_key;
            end
        end
        // expiry: remember the slot for its report, then re-arm or drop it
        if (i_cmd.expire) begin
            r_pend <= r_best;
            if (r_srep[r_best]) begin
                r_dl[r_best] <= r_now + {8'd0, re_per};
            end
        end
        if (i_cmd.slot_op) begin
            case (r_kind)
                dtt_pkg::KIND_ADD: begin
                    r_srep[id_idx] <= r_rep;
                    r_per[id_idx]  <= r_period;
                    r_dl[id_idx]   <= r_now + {8'd0, r_period};
                end
                dtt_pkg::KIND_REFRESH: begin
                    r_dl[id_idx] <= r_now + {8'd0, r_per[id_idx]};
                end
                dtt_pkg::KIND_RESET: begin
                    r_per[id_idx] <= r_period;
                    r_dl[id_idx]  <= start + {8'd0, r_period};
                end
                default: ;
            endcase
        end
        if (i_cmd.out_load) begin
            o_ok            <= i_cmd.out_ok;
            o_front_changed <= i_cmd.out_fc;
            o_last          <= i_cmd.out_last;
            case (i_cmd.out_sel)
                dtt_pkg::OSEL_OP: begin
                    o_slot_out     <= r_id;
                    o_expired      <= 1'b0;
                    o_next_wait_ms <= '0;
                end
                dtt_pkg::OSEL_QUERY: begin
                    o_slot_out     <= r_best_vld ? 4'(r_best) : 4'd0;
                    o_expired      <= 1'b0;
                    o_next_wait_ms <= !r_best_vld ? dtt_pkg::NO_WAIT :
                                      (o_stat.best_due ? 32'd0 : best_dist);
                end
                dtt_pkg::OSEL_PEND: begin
                    o_slot_out     <= 4'(r_pend);
                    o_expired      <= 1'b1;
                    o_next_wait_ms <= '0;
                end
                default: begin
                    o_slot_out     <= '0;
                    o_expired      <= 1'b0;
                    o_next_wait_ms <= '0;
                end
            endcase
        end
        if (!i_rst_n) begin
            r_act      <= '{default: 1'b0};
            r_now      <= '0;
            r_fn       <= 1'b0;
            r_best_vld <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            if (i_cmd.now_inc) begin
                r_now <= r_now + 32'd1;
            end
            if (i_cmd.fn_clear) begin
                r_fn <= 1'b0;
            end else if (i_cmd.fn_set) begin
                r_fn <= 1'b1;
            end
            if (i_cmd.latch) begin
                r_pend_vld <= 1'b0;
            end else if (i_cmd.expire) begin
                r_pend_vld <= 1'b1;
            end
            if (i_cmd.expire && !r_srep[r_best]) begin
                r_act[r_best] <= 1'b0;
            end
            if (i_cmd.slot_op) begin
                if (r_kind == dtt_pkg::KIND_ADD) begin
                    r_act[id_idx] <= 1'b1;
                end else if (r_kind == dtt_pkg::KIND_CANCEL) begin
                    r_act[id_idx] <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== rtl/dtt_ctrl.sv =====
module dtt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dtt_pkg::t_dp_cmd  o_cmd,
    input  dtt_pkg::t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE, S_DISP, S_SCAN, S_DECIDE, S_EXP, S_EMIT
    } t_state;

    t_state                     r_state, n_state;
    t_state                     r_ret, n_ret;
    logic [dtt_pkg::SLOT_W-1:0] r_idx, n_idx;
    logic [dtt_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                       r_ov, n_ov;
    dtt_pkg::t_osel             r_osel, n_osel;
    logic                       r_ook, n_ook;
    logic                       r_ofc, n_ofc;
    logic                       r_olast, n_olast;
    logic                       fc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign fc          = i_stat.best_is_id && !i_stat.fn;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_ov    = r_ov && !i_out_ready;
        n_osel  = r_osel;
        n_ook   = r_ook;
        n_ofc   = r_ofc;
        n_olast = r_olast;
        o_cmd          = '0;
        o_cmd.scan_idx = r_idx;
        o_cmd.out_sel  = r_osel;
        o_cmd.out_ok   = r_ook;
        o_cmd.out_fc   = r_ofc;
        o_cmd.out_last = r_olast;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                n_idx   = '0;
                n_cnt   = '0;
                n_osel  = dtt_pkg::OSEL_OP;
                n_ook   = 1'b0;
                n_ofc   = 1'b0;
                n_olast = 1'b1;
                n_ret   = S_IDLE;
                n_state = S_EMIT;
                if (i_stat.kind == dtt_pkg::KIND_TICK) begin
                    o_cmd.now_inc = 1'b1;
                    n_state       = S_SCAN;
                end else if (i_stat.kind == dtt_pkg::KIND_QUERY) begin
                    o_cmd.fn_clear = 1'b1;
                    n_state        = S_SCAN;
                end else if (i_stat.kind > dtt_pkg::KIND_QUERY || !i_stat.in_range) begin
                    n_ook = 1'b0;
                end else if (i_stat.kind == dtt_pkg::KIND_ADD) begin
                    o_cmd.slot_op = 1'b1;
                    n_state       = S_SCAN;
                end else if (!i_stat.id_active) begin
                    n_ook = 1'b0;
                end else if (i_stat.kind == dtt_pkg::KIND_RESET && i_stat.reset_noop) begin
                    n_ook = 1'b1;
                end else begin
                    o_cmd.slot_op = 1'b1;
                    n_ook         = 1'b1;
                    if (i_stat.kind == dtt_pkg::KIND_RESET) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                n_idx         = r_idx + dtt_pkg::SLOT_W'(1);
                if (r_idx == dtt_pkg::SLOT_W'(dtt_pkg::TIMER_SLOTS - 1)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_ret   = S_IDLE;
                n_state = S_EMIT;
                n_ook   = 1'b1;
                n_ofc   = 1'b0;
                n_olast = 1'b1;
                if (i_stat.kind == dtt_pkg::KIND_TICK) begin
                    if (i_stat.best_vld && i_stat.best_due &&
                        r_cnt < dtt_pkg::CNT_W'(dtt_pkg::MAX_RESULTS)) begin
                        // report the previous expiry before taking the next one
                        if (i_stat.pend_vld) begin
                            n_osel  = dtt_pkg::OSEL_PEND;
                            n_olast = 1'b0;
                            n_ret   = S_EXP;
                        end else begin
                            n_state = S_EXP;
                        end
                    end else begin
                        n_osel = i_stat.pend_vld ? dtt_pkg::OSEL_PEND : dtt_pkg::OSEL_QUIET;
                    end
                end else if (i_stat.kind == dtt_pkg::KIND_QUERY) begin
                    n_osel = dtt_pkg::OSEL_QUERY;
                end else begin
                    n_osel       = dtt_pkg::OSEL_OP;
                    n_ofc        = fc;
                    o_cmd.fn_set = fc;
                end
            end
            S_EXP: begin
                o_cmd.expire = 1'b1;
                n_cnt        = r_cnt + dtt_pkg::CNT_W'(1);
                n_idx        = '0;
                n_state      = S_SCAN;
            end
            S_EMIT: begin
                if (!r_ov || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ov           = 1'b1;
                    n_state        = r_ret;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_osel  <= dtt_pkg::OSEL_OP;
            r_ook   <= 1'b0;
            r_ofc   <= 1'b0;
            r_olast <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
            r_osel  <= n_osel;
            r_ook   <= n_ook;
            r_ofc   <= n_ofc;
            r_olast <= n_olast;
        end
    end

endmodule

// ===== rtl/deadline_timer_table.sv =====
// Deadline timer table: sixteen timer slots, scanned for the earliest deadline.
// Input channel i_in carries one operation per beat (add, cancel, refresh,
// reset, tick, query_next); output channel o_out returns result beats, the
// final beat of each operation marked by last.
// The block takes one operation at a time.
// An in-range add, tick, query and a reset that changes an active slot walk
// all slots once through a single compare unit, one slot a cycle.
// A tick with k expiries walks the slots k + 1 times; cancel and refresh
// do not walk the slots.
// Reset clears every slot to inactive, the millisecond counter to zero and
// the front-notify flag; i_in is ready in the first cycle after reset.
// A result beat sits in an output register: when the receiver stalls, the
// block finishes into that register and holds there until it is taken;
// a new operation may be accepted while the last result still waits.
module deadline_timer_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dtt_in_if.sink    i_in,
    dtt_out_if.source o_out
);

    dtt_pkg::t_dp_cmd  cmd;
    dtt_pkg::t_dp_stat stat;

    // controller: sequences dispatch, slot scans, expiries and result beats
    dtt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // datapath: slot storage, time counter, scan compare and result register
    dtt_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_kind          (i_in.kind),
        .i_timer_id      (i_in.timer_id),
        .i_period_ms     (i_in.period_ms),
        .i_repeat_mode   (i_in.repeat_mode),
        .i_start_now     (i_in.start_now),
        .o_slot_out      (o_out.slot_out),
        .o_expired       (o_out.expired),
        .o_ok            (o_out.ok),
        .o_front_changed (o_out.front_changed),
        .o_next_wait_ms  (o_out.next_wait_ms),
        .o_last          (o_out.last)
    );

endmodule
